// ===== src/bdqs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdqs_pkg
// Shared codes, field widths and types of the bounded deque with search.
// ----------------------------------------------------------------------------
package bdqs_pkg;

   localparam int VALUE_W = 32;
   localparam int KIND_W  = 3;
   localparam int POS_W   = 6;
   localparam int LEN_W   = 7;
   localparam int STAT_W  = 2;

   localparam logic [KIND_W-1:0] KIND_APPEND       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PREPEND      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE_LAST  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIND_FIRST   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FIND_LAST    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd6;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic done;
      logic found;
   } hit_type;

endpackage
`default_nettype wire

// ===== src/bdqs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdqs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/bdqs_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdqs_walker
// Search sequencer: reads one entry per cycle from the store, in either
// direction around the ring, and stops at the first matching word.
// ----------------------------------------------------------------------------
module bdqs_walker
   import bdqs_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            dir_last,
   input  wire logic [$clog2(DEPTH)-1:0]        first_ptr,
   input  wire logic [$clog2(DEPTH)-1:0]        first_lidx,
   input  wire logic [$clog2(DEPTH+1)-1:0]      length,
   input  wire logic [VALUE_W-1:0]              key,
   output logic                                 rd_en,
   output logic      [$clog2(DEPTH)-1:0]        rd_addr,
   input  wire logic [VALUE_W-1:0]              rd_data,
   output hit_type                              hit,
   output logic      [$clog2(DEPTH)-1:0]        hit_pos
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic               busy_ff, busy_in;
   logic               dir_ff, dir_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      lidx_ff, lidx_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic               rv_ff, rv_in;
   logic               rlast_ff, rlast_in;
   logic [AW-1:0]      rlidx_ff, rlidx_in;
   logic               issue;
   logic               match;
   logic               done;

   assign issue   = busy_ff && (left_ff != '0);
   assign match   = rv_ff && (rd_data == key_ff);
   assign done    = busy_ff && rv_ff && (match || rlast_ff);
   assign rd_en   = issue;
   assign rd_addr = ptr_ff;
   assign hit     = '{done: done, found: match};
   assign hit_pos = rlidx_ff;

   always_comb begin
      busy_in  = busy_ff;
      dir_in   = dir_ff;
      ptr_in   = ptr_ff;
      lidx_in  = lidx_ff;
      left_in  = left_ff;
      key_in   = key_ff;
      rv_in    = issue && !done;
      rlast_in = (left_ff == CW'(1));
      rlidx_in = lidx_ff;
      if (start) begin
         busy_in = 1'b1;
         dir_in  = dir_last;
         ptr_in  = first_ptr;
         lidx_in = first_lidx;
         left_in = length;
         key_in  = key;
         rv_in   = 1'b0;
      end else begin
         if (issue) begin
            left_in = left_ff - CW'(1);
            if (dir_ff) begin
               ptr_in  = (ptr_ff == '0) ? LAST_ADDR : ptr_ff - AW'(1);
               lidx_in = lidx_ff - AW'(1);
            end else begin
               ptr_in  = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + AW'(1);
               lidx_in = lidx_ff + AW'(1);
            end
         end
         if (done) begin
            busy_in = 1'b0;
            left_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         left_ff <= left_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff   <= dir_in;
      ptr_ff   <= ptr_in;
      lidx_ff  <= lidx_in;
      key_ff   <= key_in;
      rlast_ff <= rlast_in;
      rlidx_ff <= rlidx_in;
   end

endmodule
`default_nettype wire

// ===== src/bounded_deque_with_search_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top
// Fixed-capacity double-ended list of 32-bit words with first/last search.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_tuser carries the kind, req_tdata the value word.
//   rsp channel: one transfer per request with found, position, length and
//   status packed in rsp_tdata.
//   Entries sit in one RAM used as a ring; a head pointer and a count give
//   the list, so inserts and removals at either end need no walk, and the
//   result is registered the cycle after the request transfer.
//   A search walks the ring through the RAM read port, one entry per cycle,
//   and stops early on the first match. An empty-list search answers at once.
//   One request is in work at a time; req_tready is high when no search is
//   running and the result register is empty or drains in that cycle.
//   Reset empties the list at once; RAM contents are not cleared.
//   A stalled receiver holds the result in the output register and the
//   block takes no new request until it drains.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top
   import bdqs_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic [2:0]  req_tuser,   // kind[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // found[0], position[6:1],
                                         // list_length[13:7], status[15:14]
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   logic              state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic               acc;
   logic               full;
   logic               empty;
   logic [AW:0]        end_sum;
   logic [AW:0]        last_sum;
   logic [AW-1:0]      end_ptr;
   logic [AW-1:0]      last_ptr;
   logic [AW-1:0]      head_dec;
   logic [AW-1:0]      head_inc;
   logic [KIND_W-1:0]  kind;
   logic [VALUE_W-1:0] value;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               walk_start;
   logic               walk_dir;
   logic [AW-1:0]      walk_ptr;
   logic [AW-1:0]      walk_lidx;
   hit_type            hit;
   logic [AW-1:0]      hit_pos;

   assign kind  = req_tuser;
   assign value = req_tdata;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign acc        = req_tvalid && req_tready;
   assign full       = (count_ff == FULL_CNT);
   assign empty      = (count_ff == '0);

   assign end_sum  = (AW+1)'(head_ff) + (AW+1)'(count_ff);
   assign last_sum = end_sum - (AW+1)'(1);
   assign end_ptr  = (end_sum >= (AW+1)'(DEPTH)) ? AW'(end_sum - (AW+1)'(DEPTH))
                                                 : AW'(end_sum);
   assign last_ptr = (last_sum >= (AW+1)'(DEPTH)) ? AW'(last_sum - (AW+1)'(DEPTH))
                                                  : AW'(last_sum);
   assign head_dec = (head_ff == '0) ? LAST_ADDR : head_ff - AW'(1);
   assign head_inc = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = end_ptr;
      walk_start   = 1'b0;
      walk_dir     = 1'b0;
      walk_ptr     = head_ff;
      walk_lidx    = '0;

      if (acc) begin
         status_in = STATUS_OK;
         case (kind)
            KIND_APPEND: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = end_ptr;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_PREPEND: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_REMOVE_LAST: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            KIND_REMOVE_FIRST: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - CW'(1);
               end
            end
            KIND_FIND_FIRST: begin
               if (!empty) begin
                  walk_start = 1'b1;
                  walk_dir   = 1'b0;
                  walk_ptr   = head_ff;
                  walk_lidx  = '0;
               end
            end
            KIND_FIND_LAST: begin
               if (!empty) begin
                  walk_start = 1'b1;
                  walk_dir   = 1'b1;
                  walk_ptr   = last_ptr;
                  walk_lidx  = AW'(count_ff - CW'(1));
               end
            end
            KIND_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase

         if (walk_start) begin
            state_in = S_WALK;
         end else begin
            rsp_valid_in = 1'b1;
            found_in     = 1'b0;
            pos_in       = '0;
            len_in       = LEN_W'(count_in);
         end
      end

      if ((state_ff == S_WALK) && hit.done) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         found_in     = hit.found;
         pos_in       = hit.found ? POS_W'(hit_pos) : '0;
         len_in       = LEN_W'(count_ff);
         status_in    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      len_ff    <= len_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {status_ff, len_ff, pos_ff, found_ff};

   bdqs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bdqs_walker #(
      .DEPTH (DEPTH)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .start      (walk_start),
      .dir_last   (walk_dir),
      .first_ptr  (walk_ptr),
      .first_lidx (walk_lidx),
      .length     (count_ff),
      .key        (value),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .hit        (hit),
      .hit_pos    (hit_pos)
   );

   // fill level and ring head stay in range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= FULL_CNT) && (head_ff <= LAST_ADDR))
      else $error("count or head out of range");

   // no request transfer while a search runs
   a_walk_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !req_tready)
      else $error("request taken during search");

   // a match always lies inside the list
   a_hit_in_list: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WALK) && hit.done && hit.found) |->
         ((CW'(hit_pos) < count_ff)))
      else $error("search hit beyond list end");

   // each request transfer leads to a held result or a running search
   a_req_progress: assert property (@(posedge clock) disable iff (reset)
      acc |=> (rsp_valid_ff || (state_ff == S_WALK)))
      else $error("request transfer produced nothing");

   // the list only changes on a request transfer
   a_list_stable: assert property (@(posedge clock) disable iff (reset)
      !acc |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("list changed without a transfer");

endmodule
`default_nettype wire

// ===== tb/tb_bounded_deque_with_search_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search_top
// Self-checking bench for the bounded deque with search. Requests go in over
// the req stream and results come back over the rsp stream. A shadow copy of
// the list predicts each result, and the predicted results are compared field
// by field with the rsp transfers in order. Tests: directed corner cases,
// fill to capacity with overflow, a long receiver hold-off, drain from the
// front, a random mix, and a closing stretch with no idling.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search_top
   import bdqs_pkg::*;
();

   localparam int DEPTH = 64;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  position;
      logic [LEN_W-1:0]  list_length;
      logic [STAT_W-1:0] status;
   } deque_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // value[31:0]
   logic [2:0]  req_tuser;   // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // found[0], position[6:1], list_length[13:7], status[15:14]

   logic [31:0]   shadow_words [DEPTH];
   int            shadow_len = 0;
   int            target_len = 0;
   deque_rsp_type pending_rsp [$];
   int            error_count = 0;
   bit            idle_on = 1'b1;
   int            hold_off = 0;

   logic [31:0] hot_words [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h0000_0001, 32'h5A5A_5A5A,
                                  32'hA5A5_A5A5, 32'h1234_5678};

   bounded_deque_with_search_top #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Updates the shadow list and returns the result the request should give.
   function automatic deque_rsp_type apply_deque_op(input logic [KIND_W-1:0] kind,
                                                    input logic [31:0] word);
      deque_rsp_type r;
      int i;
      r = '0;
      case (kind)
         KIND_APPEND: begin
            if (shadow_len >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_words[shadow_len] = word;
               shadow_len++;
            end
         end
         KIND_PREPEND: begin
            if (shadow_len >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = shadow_len; i > 0; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[0] = word;
               shadow_len++;
            end
         end
         KIND_REMOVE_LAST: begin
            if (shadow_len == 0)
               r.status = STATUS_EMPTY;
            else
               shadow_len--;
         end
         KIND_REMOVE_FIRST: begin
            if (shadow_len == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               for (i = 1; i < shadow_len; i++)
                  shadow_words[i-1] = shadow_words[i];
               shadow_len--;
            end
         end
         KIND_FIND_FIRST: begin
            for (i = 0; i < shadow_len && !r.found; i++)
               if (shadow_words[i] == word) begin
                  r.found    = 1'b1;
                  r.position = POS_W'(i);
               end
         end
         KIND_FIND_LAST: begin
            for (i = shadow_len - 1; i >= 0 && !r.found; i--)
               if (shadow_words[i] == word) begin
                  r.found    = 1'b1;
                  r.position = POS_W'(i);
               end
         end
         KIND_CLEAR: begin
            shadow_len = 0;
         end
         default: begin
         end
      endcase
      r.list_length = LEN_W'(shadow_len);
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5 && shadow_len > 0)
         return shadow_words[$urandom_range(0, shadow_len - 1)];
      else if (r < 8)
         return hot_words[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [31:0] word);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(apply_deque_op(kind, word));
   endtask

   // Random request; inserts lean toward a target length that wanders.
   task automatic random_request();
      logic [KIND_W-1:0] kind;
      int r;
      if ($urandom_range(0, 149) == 0)
         target_len = ($urandom_range(0, 2) == 0) ? DEPTH : $urandom_range(0, DEPTH);
      r = $urandom_range(0, 99);
      if (r < 1)
         kind = KIND_CLEAR;
      else if (r < 3)
         kind = KIND_UNUSED;
      else if (r < 16)
         kind = KIND_FIND_FIRST;
      else if (r < 29)
         kind = KIND_FIND_LAST;
      else if ($urandom_range(0, 3) < ((shadow_len < target_len) ? 3 : 1))
         kind = $urandom_range(0, 1) ? KIND_PREPEND : KIND_APPEND;
      else
         kind = $urandom_range(0, 1) ? KIND_REMOVE_FIRST : KIND_REMOVE_LAST;
      send_item(kind, pick_word());
   endtask

   task automatic test_directed();
      send_item(KIND_REMOVE_LAST,  32'h0000_0000);
      send_item(KIND_REMOVE_FIRST, 32'hFFFF_FFFF);
      send_item(KIND_FIND_FIRST,   32'h0000_0000);
      send_item(KIND_FIND_LAST,    32'h0000_0000);
      send_item(KIND_APPEND,       32'h8000_0000);
      send_item(KIND_APPEND,       32'h7FFF_FFFF);
      send_item(KIND_PREPEND,      32'hFFFF_FFFF);
      send_item(KIND_PREPEND,      32'h0000_0000);
      send_item(KIND_APPEND,       32'h7FFF_FFFF);
      send_item(KIND_PREPEND,      32'h7FFF_FFFF);
      send_item(KIND_FIND_FIRST,   32'h7FFF_FFFF);
      send_item(KIND_FIND_LAST,    32'h7FFF_FFFF);
      send_item(KIND_FIND_FIRST,   32'h8000_0000);
      send_item(KIND_FIND_LAST,    32'h1234_5678);
      send_item(KIND_UNUSED,       32'hFFFF_FFFF);
      send_item(KIND_REMOVE_FIRST, 32'h0000_0000);
      send_item(KIND_REMOVE_LAST,  32'h0000_0000);
      send_item(KIND_FIND_LAST,    32'h7FFF_FFFF);
      send_item(KIND_CLEAR,        32'h0000_0000);
      send_item(KIND_FIND_FIRST,   32'h0000_0000);
      send_item(KIND_REMOVE_LAST,  32'h0000_0000);
      send_item(KIND_CLEAR,        32'hFFFF_FFFF);
   endtask

   task automatic test_fill_and_overflow();
      while (shadow_len < DEPTH)
         send_item($urandom_range(0, 1) ? KIND_PREPEND : KIND_APPEND, $urandom());
      send_item(KIND_APPEND,     32'h7FFF_FFFF);
      send_item(KIND_PREPEND,    32'h8000_0000);
      send_item(KIND_FIND_FIRST, shadow_words[DEPTH-1]);
      send_item(KIND_FIND_LAST,  shadow_words[0]);
      send_item(KIND_FIND_FIRST, 32'h8000_0000);
      send_item(KIND_FIND_LAST,  shadow_words[DEPTH/2]);
   endtask

   // Receiver holds off long enough for requests to back up at req_tready.
   task automatic test_receiver_hold();
      hold_off = 400;
      repeat (40) random_request();
   endtask

   task automatic test_drain_front();
      while (shadow_len < DEPTH / 2)
         send_item(KIND_APPEND, pick_word());
      while (shadow_len > 0) begin
         if ($urandom_range(0, 7) == 0)
            send_item(KIND_FIND_LAST, pick_word());
         send_item(KIND_REMOVE_FIRST, $urandom());
      end
      send_item(KIND_REMOVE_FIRST, 32'h0000_0000);
      send_item(KIND_REMOVE_LAST,  32'hFFFF_FFFF);
      send_item(KIND_FIND_LAST,    32'hFFFF_FFFF);
   endtask

   task automatic test_random_mix(input int n);
      repeat (n) random_request();
   endtask

   task automatic test_no_idle(input int n);
      idle_on = 1'b0;
      repeat (n) random_request();
   endtask

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      deque_rsp_type seen;
      deque_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            seen.found       = rsp_tdata[0];
            seen.position    = rsp_tdata[6:1];
            seen.list_length = rsp_tdata[13:7];
            seen.status      = rsp_tdata[15:14];
            if (pending_rsp.size() == 0) begin
               $error("rsp transfer with nothing expected: rsp_tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (seen.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, seen.found);
                  error_count++;
               end
               if (seen.position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position, seen.position);
                  error_count++;
               end
               if (seen.list_length !== want.list_length) begin
                  $error("list_length: expected %0d, actual %0d",
                         want.list_length, seen.list_length);
                  error_count++;
               end
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, seen.status);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_and_overflow();
      test_receiver_hold();
      test_drain_front();
      test_random_mix(850);
      test_no_idle(120);

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
src/bdqs_pkg.sv
src/bdqs_ram.sv
src/bdqs_walker.sv
src/bounded_deque_with_search_top.sv
tb/tb_bounded_deque_with_search_top.sv
